>>> sv/hth_pkg.sv
// Shared types and constants for the heightmap triangle height block.
package hth_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z     = 3'd5;

  localparam logic signed [31:0] ORIGIN_X_RST = -32'sd1024000;
  localparam logic signed [31:0] ORIGIN_Z_RST = 32'sd1024000;
  localparam logic [15:0]        CELL_SIZE_RST = 16'd20480;
  localparam logic [6:0]         CELLS_RST     = 7'd100;

  // vertex index arithmetic width, wide enough to compare against store depths up to 131071
  localparam int IDX_W = 17;
  // quotient bits of the cell search and of the plane division
  localparam int CELL_QW  = 7;
  localparam int PLANE_QW = 35;

  typedef struct packed {
    logic               operation;
    logic [13:0]        vertex_index;
    logic signed [31:0] height_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_z;
  } hth_in_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               out_of_range;
  } hth_out_t;

endpackage

>>> sv/heightmap_triangle_height_top.sv
// Heightmap triangle height: pipelined terrain height query over a vertex store.
//
// One item is accepted per clock cycle while in_stall is low, writes and queries
// alike. The pipeline has one subtract stage, an eight-stage cell search (a load
// stage, then one quotient bit per stage over 7 bits), address, memory, select,
// multiply and sum stages, and a 36-stage plane divider (a load stage, then one
// quotient bit per stage over 35 bits), then the output register.
// Four vertex heights are read per query
// from two copies of the vertex store, each read at two addresses per cycle.
// A vertex write takes effect in pipeline order, so a query accepted after a
// write sees it. Writes produce no result. The store is not cleared at reset;
// read only vertices that were written. An output skid register lets the block
// keep accepting while one result waits; in_stall rises only once it is full.
module heightmap_triangle_height_top #(
  parameter int MAX_VERTICES = 16384
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  hth_pkg::hth_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output hth_pkg::hth_out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hth_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);
  import hth_pkg::*;

  localparam int AW     = $clog2(MAX_VERTICES);
  localparam int ST_SA  = CELL_QW + 2;
  localparam int ST_SM  = ST_SA + 1;
  localparam int NP     = ST_SM + 4 + PLANE_QW + 1;

  typedef struct packed {
    logic               op;
    logic [13:0]        vidx;
    logic signed [31:0] hval;
    logic signed [32:0] dx;
    logic signed [32:0] ez;
  } s1_t;

  typedef struct packed {
    logic               op;
    logic [13:0]        vidx;
    logic signed [31:0] hval;
    logic               oor;
    logic [15:0]        rx;
    logic [CELL_QW-1:0] lx;
    logic [15:0]        rz;
    logic [CELL_QW-1:0] lz;
  } dv_t;

  typedef struct packed {
    logic               op;
    logic [13:0]        vidx;
    logic signed [31:0] hval;
    logic               oor;
    logic [IDX_W-1:0]   lu;
    logic [IDX_W-1:0]   ld;
    logic [15:0]        fx;
    logic [15:0]        fz;
    logic [31:0]        pa;
    logic [31:0]        pb;
  } sa_t;

  typedef struct packed {
    logic        oor;
    logic        lower;
    logic [15:0] fx;
    logic [15:0] fz;
  } sm_t;

  typedef struct packed {
    logic               oor;
    logic signed [31:0] hb;
    logic signed [32:0] da;
    logic signed [32:0] db;
    logic [31:0]        m1;
    logic [31:0]        m2;
  } sp_t;

  typedef struct packed {
    logic               oor;
    logic signed [31:0] hb;
    logic signed [65:0] n1;
    logic signed [65:0] n2;
  } mu_t;

  typedef struct packed {
    logic               oor;
    logic signed [31:0] hb;
    logic signed [66:0] n;
  } su_t;

  typedef struct packed {
    logic                oor;
    logic                neg;
    logic signed [31:0]  hb;
    logic [31:0]         r;
    logic [PLANE_QW-1:0] q;
  } qd_t;

  // configuration
  logic signed [31:0] origin_x_r, origin_z_r;
  logic [15:0]        csx_r, csz_r;
  logic [6:0]         cells_x_r, cells_z_r;
  logic [22:0]        lim_x_r, lim_z_r;
  logic [31:0]        den_r;
  logic               size_zero_r;
  logic [7:0]         pitch;

  // pipeline
  logic [NP-1:0] v_r, v_nxt;
  logic          adv;
  s1_t s1_r, s1_nxt;
  dv_t dv_r   [CELL_QW+1];
  dv_t dv_nxt [CELL_QW+1];
  sa_t sa_r, sa_nxt;
  sm_t sm_r, sm_nxt;
  sp_t sp_r, sp_nxt;
  mu_t mu_r, mu_nxt;
  su_t su_r, su_nxt;
  qd_t qd_r   [PLANE_QW+1];
  qd_t qd_nxt [PLANE_QW+1];

  // vertex store, two copies for four reads per cycle
  logic [31:0]        mem_a [MAX_VERTICES];
  logic [31:0]        mem_b [MAX_VERTICES];
  logic signed [31:0] h_ld_r, h_lu_r, h_ld1_r, h_lu1_r;
  logic [IDX_W-1:0]   widx, ld1, lu1;
  logic               wr_en;

  // output side
  hth_out_t res;
  logic signed [36:0] ys;
  logic out_v_r, out_v_nxt, skid_v_r, skid_v_nxt, out_free, fin_v;
  hth_out_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  function automatic dv_t cell_step(dv_t s, logic [15:0] csx, logic [15:0] csz);
    logic [16:0] tx, tz;
    logic        gx, gz;
    dv_t         o;
    o  = s;
    tx = {s.rx, s.lx[CELL_QW-1]};
    tz = {s.rz, s.lz[CELL_QW-1]};
    gx = tx >= {1'b0, csx};
    gz = tz >= {1'b0, csz};
    o.rx = gx ? 16'(tx - {1'b0, csx}) : tx[15:0];
    o.rz = gz ? 16'(tz - {1'b0, csz}) : tz[15:0];
    o.lx = {s.lx[CELL_QW-2:0], gx};
    o.lz = {s.lz[CELL_QW-2:0], gz};
    return o;
  endfunction

  function automatic qd_t plane_step(qd_t s, logic [31:0] den);
    logic [32:0] t;
    logic        g;
    qd_t         o;
    o = s;
    t = {s.r, s.q[PLANE_QW-1]};
    g = t >= {1'b0, den};
    o.r = g ? 32'(t - {1'b0, den}) : t[31:0];
    o.q = {s.q[PLANE_QW-2:0], g};
    return o;
  endfunction

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= ORIGIN_X_RST;
      origin_z_r <= ORIGIN_Z_RST;
      csx_r      <= CELL_SIZE_RST;
      csz_r      <= CELL_SIZE_RST;
      cells_x_r  <= CELLS_RST;
      cells_z_r  <= CELLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:    origin_x_r <= cfg_data;
        CFG_ORIGIN_Z:    origin_z_r <= cfg_data;
        CFG_CELL_SIZE_X: csx_r      <= cfg_data[15:0];
        CFG_CELL_SIZE_Z: csz_r      <= cfg_data[15:0];
        CFG_CELLS_X:     cells_x_r  <= cfg_data[6:0];
        CFG_CELLS_Z:     cells_z_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // derived grid constants, registered from the configuration, settled in the cycle after a write
  always_ff @(posedge clk) begin
    lim_x_r     <= 23'(cells_x_r) * 23'(csx_r);
    lim_z_r     <= 23'(cells_z_r) * 23'(csz_r);
    den_r       <= 32'(csx_r) * 32'(csz_r);
    size_zero_r <= (csx_r == 16'd0) || (csz_r == 16'd0);
  end

  assign pitch = {1'b0, cells_x_r} + 8'd1;

  // ---------------- pipeline control ----------------
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  always_comb begin
    v_nxt    = {v_r[NP-2:0], in_valid};
    // drop writes once they reach the store
    v_nxt[ST_SM] = v_r[ST_SA] && (sa_r.op == OP_QUERY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  // ---------------- stage logic ----------------
  always_comb begin
    s1_nxt.op   = in_data.operation;
    s1_nxt.vidx = in_data.vertex_index;
    s1_nxt.hval = in_data.height_value;
    s1_nxt.dx   = {in_data.query_x[31], in_data.query_x} - {origin_x_r[31], origin_x_r};
    s1_nxt.ez   = {origin_z_r[31], origin_z_r} - {in_data.query_z[31], in_data.query_z};
  end

  always_comb begin
    dv_nxt[0].op   = s1_r.op;
    dv_nxt[0].vidx = s1_r.vidx;
    dv_nxt[0].hval = s1_r.hval;
    dv_nxt[0].oor  = s1_r.dx[32] || s1_r.ez[32] || size_zero_r
                     || (s1_r.dx[31:0] >= {9'd0, lim_x_r})
                     || (s1_r.ez[31:0] >= {9'd0, lim_z_r});
    dv_nxt[0].rx   = s1_r.dx[CELL_QW+15:CELL_QW];
    dv_nxt[0].lx   = s1_r.dx[CELL_QW-1:0];
    dv_nxt[0].rz   = s1_r.ez[CELL_QW+15:CELL_QW];
    dv_nxt[0].lz   = s1_r.ez[CELL_QW-1:0];
    for (int j = 1; j <= CELL_QW; j++) begin
      dv_nxt[j] = cell_step(dv_r[j-1], csx_r, csz_r);
    end
  end

  always_comb begin
    sa_nxt.op   = dv_r[CELL_QW].op;
    sa_nxt.vidx = dv_r[CELL_QW].vidx;
    sa_nxt.hval = dv_r[CELL_QW].hval;
    sa_nxt.oor  = dv_r[CELL_QW].oor;
    sa_nxt.lu   = IDX_W'(dv_r[CELL_QW].lz) * IDX_W'(pitch) + IDX_W'(dv_r[CELL_QW].lx);
    sa_nxt.ld   = sa_nxt.lu + IDX_W'(pitch);
    sa_nxt.fx   = dv_r[CELL_QW].rx;
    sa_nxt.fz   = dv_r[CELL_QW].rz;
    sa_nxt.pa   = 32'(csx_r) * 32'(dv_r[CELL_QW].rz);
    sa_nxt.pb   = 32'(csz_r) * 32'(dv_r[CELL_QW].rx);
  end

  assign ld1   = sa_r.ld + IDX_W'(1);
  assign lu1   = sa_r.lu + IDX_W'(1);
  assign widx  = IDX_W'(sa_r.vidx);
  assign wr_en = v_r[ST_SA] && (sa_r.op == OP_WRITE) && (widx < IDX_W'(MAX_VERTICES));

  always_comb begin
    sm_nxt.oor   = sa_r.oor || (ld1 >= IDX_W'(MAX_VERTICES));
    sm_nxt.lower = sa_r.pa >= sa_r.pb;
    sm_nxt.fx    = sa_r.fx;
    sm_nxt.fz    = sa_r.fz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wr_en) begin
        mem_a[widx[AW-1:0]] <= sa_r.hval;
        mem_b[widx[AW-1:0]] <= sa_r.hval;
      end
      h_ld_r  <= mem_a[sa_r.ld[AW-1:0]];
      h_lu_r  <= mem_a[sa_r.lu[AW-1:0]];
      h_ld1_r <= mem_b[ld1[AW-1:0]];
      h_lu1_r <= mem_b[lu1[AW-1:0]];
    end
  end

  always_comb begin
    logic [15:0] a1, a2;
    sp_nxt.oor = sm_r.oor;
    if (sm_r.lower) begin
      sp_nxt.hb = h_ld_r;
      sp_nxt.da = {h_ld1_r[31], h_ld1_r} - {h_ld_r[31], h_ld_r};
      sp_nxt.db = {h_lu_r[31], h_lu_r} - {h_ld_r[31], h_ld_r};
      a1 = sm_r.fx;
      a2 = csz_r - sm_r.fz;
    end else begin
      sp_nxt.hb = h_lu1_r;
      sp_nxt.da = {h_lu_r[31], h_lu_r} - {h_lu1_r[31], h_lu1_r};
      sp_nxt.db = {h_ld1_r[31], h_ld1_r} - {h_lu1_r[31], h_lu1_r};
      a1 = csx_r - sm_r.fx;
      a2 = sm_r.fz;
    end
    sp_nxt.m1 = 32'(a1) * 32'(csz_r);
    sp_nxt.m2 = 32'(a2) * 32'(csx_r);
  end

  always_comb begin
    mu_nxt.oor = sp_r.oor;
    mu_nxt.hb  = sp_r.hb;
    mu_nxt.n1  = sp_r.da * $signed({1'b0, sp_r.m1});
    mu_nxt.n2  = sp_r.db * $signed({1'b0, sp_r.m2});
  end

  always_comb begin
    su_nxt.oor = mu_r.oor;
    su_nxt.hb  = mu_r.hb;
    su_nxt.n   = {mu_r.n1[65], mu_r.n1} + {mu_r.n2[65], mu_r.n2};
  end

  always_comb begin
    logic [66:0] mag;
    mag = su_r.n[66] ? (~su_r.n + 67'd1) : su_r.n;
    qd_nxt[0].oor = su_r.oor;
    qd_nxt[0].neg = su_r.n[66];
    qd_nxt[0].hb  = su_r.hb;
    qd_nxt[0].r   = 32'(mag[65:PLANE_QW]);
    qd_nxt[0].q   = mag[PLANE_QW-1:0];
    for (int j = 1; j <= PLANE_QW; j++) begin
      qd_nxt[j] = plane_step(qd_r[j-1], den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      dv_r  <= dv_nxt;
      sa_r  <= sa_nxt;
      sm_r  <= sm_nxt;
      sp_r  <= sp_nxt;
      mu_r  <= mu_nxt;
      su_r  <= su_nxt;
      qd_r  <= qd_nxt;
    end
  end

  // ---------------- final add, saturate, output skid ----------------
  always_comb begin
    if (qd_r[PLANE_QW].neg) begin
      ys = {{5{qd_r[PLANE_QW].hb[31]}}, qd_r[PLANE_QW].hb} - {2'b00, qd_r[PLANE_QW].q};
    end else begin
      ys = {{5{qd_r[PLANE_QW].hb[31]}}, qd_r[PLANE_QW].hb} + {2'b00, qd_r[PLANE_QW].q};
    end
    res.out_of_range = qd_r[PLANE_QW].oor;
    if (qd_r[PLANE_QW].oor) begin
      res.height = 32'sd0;
    end else if (ys[36:31] == {6{ys[31]}}) begin
      res.height = ys[31:0];
    end else if (ys[36]) begin
      res.height = 32'sh8000_0000;
    end else begin
      res.height = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    out_free   = !out_v_r || !out_stall;
    fin_v      = v_r[NP-1] && adv;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (out_free) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (fin_v) begin
      if (out_free) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_d_r.out_of_range |-> out_d_r.height == 32'sd0)
    else $error("out of range result carries a nonzero height");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(v_r))
    else $error("pipeline moved while skid register was full");

  a_write_drop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[ST_SA] && (sa_r.op == OP_WRITE) |=> !v_r[ST_SM])
    else $error("vertex write continued past the store stage");
`endif

endmodule
